>>> hw/rtl/spt_pkg.sv
// Package for the signal plausibility table: codes, item types and the
// per-channel record kept in the channel RAM. No dependencies.
`default_nettype none

package spt_pkg;

   localparam int NUM_CHANNELS_DEF = 32;
   localparam int VALUE_W          = 32;
   localparam int TIME_W           = 48;
   localparam int RATE_W           = 31;
   localparam int WINDOW_W         = 16;
   localparam int HITS_W           = 16;
   localparam int TOTAL_W          = 6;
   localparam int MS_PER_S         = 1000;
   // dt is multiplied in two halves of this many bits
   localparam int DT_HALF          = 24;

   // request codes
   localparam logic [1:0] REQ_DEFINE = 2'd0;
   localparam logic [1:0] REQ_UPDATE = 2'd1;
   localparam logic [1:0] REQ_SCAN   = 2'd2;

   // validity codes
   localparam logic [2:0] V_NA      = 3'd0;
   localparam logic [2:0] V_VALID   = 3'd1;
   localparam logic [2:0] V_RANGE   = 3'd2;
   localparam logic [2:0] V_INVALID = 3'd3;
   localparam logic [2:0] V_STALE   = 3'd4;

   // classified command kinds
   localparam logic [2:0] CMD_DEFINE  = 3'd0;
   localparam logic [2:0] CMD_UPDATE  = 3'd1;
   localparam logic [2:0] CMD_SCAN    = 3'd2;
   localparam logic [2:0] CMD_DROP_CH = 3'd3; // channel outside the table
   localparam logic [2:0] CMD_DROP    = 3'd4; // unused request code

   typedef struct packed {
      logic [2:0]                kind;
      logic [4:0]                channel;
      logic signed [VALUE_W-1:0] sample;
      logic [TIME_W-1:0]         now_ms;
      logic [TIME_W-1:0]         source_ms;
      logic signed [VALUE_W-1:0] lower_limit;
      logic signed [VALUE_W-1:0] upper_limit;
      logic [2:0]                flags;    // critical, has_upper, has_lower
      logic [RATE_W-1:0]         rate_limit;
      logic [WINDOW_W-1:0]       fresh_window;
   } cmd_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] lo;
      logic signed [VALUE_W-1:0] hi;
      logic [2:0]                flags;
      logic [RATE_W-1:0]         rate;
      logic [WINDOW_W-1:0]       window;
      logic signed [VALUE_W-1:0] value;
      logic [2:0]                validity;
      logic [TIME_W-1:0]         stamp;
      logic [TIME_W-1:0]         source;
      logic [HITS_W-1:0]         count;
   } entry_type;

   typedef struct packed {
      logic [4:0]                out_channel;
      logic signed [VALUE_W-1:0] stored_value;
      logic [2:0]                validity;
      logic [2:0]                prior_validity;
      logic                      accepted;
      logic                      degraded;
      logic [TOTAL_W-1:0]        bad_count;
      logic [HITS_W-1:0]         hits;
      logic                      last;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [4:0] ch,
                                        input logic signed [VALUE_W-1:0] val,
                                        input logic [2:0] vd,
                                        input logic [2:0] pv,
                                        input logic acc,
                                        input logic [TOTAL_W-1:0] total,
                                        input logic [HITS_W-1:0] hits,
                                        input logic last);
      rsp_type r;
      r.out_channel    = ch;
      r.stored_value   = val;
      r.validity       = vd;
      r.prior_validity = pv;
      r.accepted       = acc;
      r.degraded       = (total != '0);
      r.bad_count      = total;
      r.hits           = hits;
      r.last           = last;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/spt_req_if.sv
// Request channel interface: valid/ready handshake and request payload.
// Depends on spt_pkg.
`default_nettype none

interface spt_req_if import spt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic [4:0]                channel;
   logic signed [VALUE_W-1:0] sample;
   logic [TIME_W-1:0]         now_ms;
   logic [TIME_W-1:0]         source_ms;
   logic signed [VALUE_W-1:0] lower_limit;
   logic signed [VALUE_W-1:0] upper_limit;
   logic                      has_lower;
   logic                      has_upper;
   logic                      critical;
   logic [RATE_W-1:0]         rate_limit;
   logic [WINDOW_W-1:0]       fresh_window;

   modport source (output valid, req_type, channel, sample, now_ms, source_ms,
                   lower_limit, upper_limit, has_lower, has_upper, critical,
                   rate_limit, fresh_window, input ready);
   modport sink (input valid, req_type, channel, sample, now_ms, source_ms,
                 lower_limit, upper_limit, has_lower, has_upper, critical,
                 rate_limit, fresh_window, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spt_rsp_if.sv
// Response channel interface: valid/ready handshake and result payload.
// Depends on spt_pkg.
`default_nettype none

interface spt_rsp_if import spt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [4:0]                out_channel;
   logic signed [VALUE_W-1:0] stored_value;
   logic [2:0]                validity;
   logic [2:0]                prior_validity;
   logic                      accepted;
   logic                      degraded;
   logic [TOTAL_W-1:0]        bad_count;
   logic [HITS_W-1:0]         hits;
   logic                      last;

   modport source (output valid, out_channel, stored_value, validity,
                   prior_validity, accepted, degraded, bad_count, hits, last,
                   input ready);
   modport sink (input valid, out_channel, stored_value, validity,
                 prior_validity, accepted, degraded, bad_count, hits, last,
                 output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spt_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wen,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             ren,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/spt_front.sv
// Front end: accepts request items, classifies them and queues them in a
// two-entry queue for the back end. Depends on spt_pkg, spt_req_if.
`default_nettype none

module spt_front import spt_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   spt_req_if.sink   req_chan,
   output logic      q_valid,
   output cmd_type   q_cmd,
   input  wire logic q_pop
);

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       in_table;
   logic       push;

   // classify the incoming item
   always_comb begin
      in_table          = (int'(req_chan.channel) < NUM_CHANNELS);
      cls.channel       = req_chan.channel;
      cls.sample        = req_chan.sample;
      cls.now_ms        = req_chan.now_ms;
      cls.source_ms     = req_chan.source_ms;
      cls.lower_limit   = req_chan.lower_limit;
      cls.upper_limit   = req_chan.upper_limit;
      cls.flags         = {req_chan.critical, req_chan.has_upper, req_chan.has_lower};
      cls.rate_limit    = req_chan.rate_limit;
      cls.fresh_window  = req_chan.fresh_window;
      unique case (req_chan.req_type)
         REQ_DEFINE: cls.kind = in_table ? CMD_DEFINE : CMD_DROP_CH;
         REQ_UPDATE: cls.kind = in_table ? CMD_UPDATE : CMD_DROP_CH;
         REQ_SCAN:   cls.kind = CMD_SCAN;
         default:    cls.kind = CMD_DROP;
      endcase
   end

   // queue control
   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (cnt_ff != 2'd0);
   assign q_cmd          = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = q_pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/spt_back.sv
// Back end: sequencer that executes queued commands against the channel RAM
// and drives the result register. Depends on spt_pkg, spt_rsp_if, spt_ram.
`default_nettype none

module spt_back import spt_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   spt_rsp_if.source    rsp_chan
);

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CHANNELS - 1);
   localparam int PROD_W = RATE_W + TIME_W + 1;
   localparam int LHS_W  = VALUE_W + 11;
   localparam int PART_W = RATE_W + DT_HALF;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ZERO      = 4'd1;
   localparam logic [3:0] S_DECIDE    = 4'd2;
   localparam logic [3:0] S_MUL_LO    = 4'd3;
   localparam logic [3:0] S_MUL_HI    = 4'd4;
   localparam logic [3:0] S_FINISH    = 4'd5;
   localparam logic [3:0] S_SCAN_RD   = 4'd6;
   localparam logic [3:0] S_SCAN_EVAL = 4'd7;
   localparam logic [3:0] S_LIST      = 4'd8;
   localparam logic [3:0] S_LIST_EMIT = 4'd9;
   localparam logic [3:0] S_CLOSE     = 4'd10;

   logic [3:0]              state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [NUM_CHANNELS-1:0] defined_ff, defined_in;
   logic [NUM_CHANNELS-1:0] changed_ff, changed_in;
   logic                    started_ff, started_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic                    out_valid_ff;
   rsp_type                 out_ff, out_data;
   logic                    out_load;
   logic signed [VALUE_W-1:0] v_ff, v_in;
   logic [2:0]              newv_ff, newv_in;
   logic                    chk_ff, chk_in;
   logic [LHS_W-1:0]        lhs_ff, lhs_in;
   logic [TIME_W-1:0]       dt_ff, dt_in;
   logic [PART_W-1:0]       plo_ff, plo_in;
   logic [PART_W-1:0]       phi_ff, phi_in;

   // channel RAM
   logic                    ren, wen;
   logic [AW-1:0]           raddr, waddr;
   logic [$bits(entry_type)-1:0] rdata_raw, wdata_raw;
   entry_type               ent, wdata;

   spt_ram #(.WIDTH($bits(entry_type)), .DEPTH(NUM_CHANNELS)) u_ram (
      .clock (clock),
      .wen   (wen),
      .waddr (waddr),
      .wdata (wdata_raw),
      .ren   (ren),
      .raddr (raddr),
      .rdata (rdata_raw)
   );

   assign ent       = entry_type'(rdata_raw);
   assign wdata_raw = wdata;

   // datapath helpers
   logic [AW-1:0]             cidx;
   logic                      out_free;
   logic                      below, above;
   logic signed [VALUE_W-1:0] clamp1, clamp;
   logic signed [VALUE_W:0]   diff;
   logic [VALUE_W:0]          adiff;
   logic [PROD_W-1:0]         prod;
   logic [2:0]                newv_fin;
   logic [TOTAL_W-1:0]        total_inc, total_upd;
   logic [HITS_W-1:0]         count_inc;
   logic [TIME_W-1:0]         age;
   logic                      stale;
   logic [4:0]                drop_ch;

   always_comb begin
      cidx     = AW'(cmd_ff.channel);
      out_free = !out_valid_ff || rsp_chan.ready;
      // range check and clamp, lower limit first
      below  = ent.flags[0] && (cmd_ff.sample < ent.lo);
      above  = ent.flags[1] && (cmd_ff.sample > ent.hi);
      clamp1 = below ? ent.lo : cmd_ff.sample;
      clamp  = (ent.flags[1] && (clamp1 > ent.hi)) ? ent.hi : clamp1;
      // rate check operands
      diff   = $signed({cmd_ff.sample[VALUE_W-1], cmd_ff.sample})
             - $signed({ent.value[VALUE_W-1], ent.value});
      adiff  = diff[VALUE_W] ? (VALUE_W+1)'(-diff) : (VALUE_W+1)'(diff);
      prod   = (PROD_W'(phi_ff) << DT_HALF) + PROD_W'(plo_ff);
      newv_fin = (chk_ff && (PROD_W'(lhs_ff) > prod)) ? V_INVALID : newv_ff;
      total_inc = (total_ff == '1) ? total_ff : total_ff + 1'b1;
      if (ent.validity == V_VALID && newv_fin != V_VALID) begin
         total_upd = total_inc;
      end else if (ent.validity != V_VALID && newv_fin == V_VALID &&
                   total_ff != '0) begin
         total_upd = total_ff - 1'b1;
      end else begin
         total_upd = total_ff;
      end
      count_inc = (ent.count == '1) ? ent.count : ent.count + 1'b1;
      // freshness
      age   = cmd_ff.now_ms - ent.stamp;
      stale = defined_ff[idx_ff] && (ent.validity == V_VALID) &&
              (cmd_ff.now_ms > ent.stamp) && (age > TIME_W'(ent.window));
      drop_ch = (cmd_ff.kind == CMD_DROP_CH) ? cmd_ff.channel : 5'd0;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      defined_in = defined_ff;
      changed_in = changed_ff;
      started_in = started_ff;
      total_in   = total_ff;
      v_in       = v_ff;
      newv_in    = newv_ff;
      chk_in     = chk_ff;
      lhs_in     = lhs_ff;
      dt_in      = dt_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;
      q_pop      = 1'b0;
      ren        = 1'b0;
      raddr      = idx_ff;
      wen        = 1'b0;
      waddr      = cidx;
      wdata      = ent;
      out_load   = 1'b0;
      out_data   = out_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.kind)
                  CMD_DEFINE, CMD_UPDATE: begin
                     ren      = 1'b1;
                     raddr    = AW'(q_cmd.channel);
                     state_in = S_DECIDE;
                  end
                  CMD_SCAN: begin
                     idx_in     = '0;
                     changed_in = '0;
                     state_in   = S_SCAN_RD;
                  end
                  default: state_in = S_ZERO;
               endcase
            end
         end

         S_ZERO: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = make_rsp(drop_ch, '0, V_NA, V_NA, 1'b0, total_ff, '0, 1'b1);
               state_in = S_IDLE;
            end
         end

         S_DECIDE: begin
            if (cmd_ff.kind == CMD_DEFINE) begin
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = S_IDLE;
                  if (defined_ff[cidx]) begin
                     out_data = make_rsp(cmd_ff.channel, ent.value, ent.validity,
                                         ent.validity, 1'b0, total_ff, ent.count, 1'b1);
                  end else if (started_ff) begin
                     out_data = make_rsp(cmd_ff.channel, '0, V_NA, V_NA, 1'b0,
                                         total_ff, '0, 1'b1);
                  end else begin
                     wen              = 1'b1;
                     wdata.lo         = cmd_ff.lower_limit;
                     wdata.hi         = cmd_ff.upper_limit;
                     wdata.flags      = cmd_ff.flags;
                     wdata.rate       = cmd_ff.rate_limit;
                     wdata.window     = cmd_ff.fresh_window;
                     wdata.value      = cmd_ff.sample;
                     wdata.validity   = V_NA;
                     wdata.stamp      = '0;
                     wdata.source     = '0;
                     wdata.count      = '0;
                     defined_in[cidx] = 1'b1;
                     out_data = make_rsp(cmd_ff.channel, cmd_ff.sample, V_NA, V_NA,
                                         1'b1, total_ff, '0, 1'b1);
                  end
               end
            end else if (!defined_ff[cidx]) begin
               if (out_free) begin
                  out_load = 1'b1;
                  out_data = make_rsp(cmd_ff.channel, '0, V_NA, V_NA, 1'b0,
                                      total_ff, '0, 1'b1);
                  state_in = S_IDLE;
               end
            end else begin
               v_in     = clamp;
               newv_in  = ((below || above) && ent.flags[2]) ? V_RANGE : V_VALID;
               chk_in   = (ent.rate != '0) && (ent.validity == V_VALID) &&
                          (ent.stamp != '0) && (cmd_ff.now_ms > ent.stamp);
               lhs_in   = LHS_W'(adiff) * LHS_W'(MS_PER_S);
               dt_in    = age;
               state_in = S_MUL_LO;
            end
         end

         S_MUL_LO: begin
            plo_in   = PART_W'(ent.rate) * PART_W'(dt_ff[DT_HALF-1:0]);
            state_in = S_MUL_HI;
         end

         S_MUL_HI: begin
            phi_in   = PART_W'(ent.rate) * PART_W'(dt_ff[TIME_W-1:DT_HALF]);
            state_in = S_FINISH;
         end

         S_FINISH: begin
            if (out_free) begin
               wen            = 1'b1;
               wdata.value    = v_ff;
               wdata.validity = newv_fin;
               wdata.stamp    = cmd_ff.now_ms;
               wdata.source   = cmd_ff.source_ms;
               wdata.count    = count_inc;
               started_in     = 1'b1;
               total_in       = total_upd;
               out_load       = 1'b1;
               out_data = make_rsp(cmd_ff.channel, v_ff, newv_fin, ent.validity,
                                   newv_fin == V_VALID, total_upd, count_inc, 1'b1);
               state_in = S_IDLE;
            end
         end

         // first pass: mark aged channels stale
         S_SCAN_RD: begin
            ren      = 1'b1;
            state_in = S_SCAN_EVAL;
         end

         S_SCAN_EVAL: begin
            if (stale) begin
               wen                = 1'b1;
               waddr              = idx_ff;
               wdata.validity     = V_STALE;
               changed_in[idx_ff] = 1'b1;
               total_in           = total_inc;
            end
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_LIST;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end

         // second pass: report each change with the final totals
         S_LIST: begin
            if (changed_ff[idx_ff]) begin
               ren      = 1'b1;
               state_in = S_LIST_EMIT;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_CLOSE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_LIST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = make_rsp(5'(idx_ff), ent.value, V_STALE, V_VALID, 1'b0,
                                   total_ff, ent.count, 1'b0);
               if (idx_ff == LAST_IDX) begin
                  state_in = S_CLOSE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_LIST;
               end
            end
         end

         S_CLOSE: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = make_rsp(5'd0, '0, V_NA, V_NA, 1'b0, total_ff, '0, 1'b1);
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         defined_ff   <= '0;
         changed_ff   <= '0;
         started_ff   <= 1'b0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         defined_ff <= defined_in;
         changed_ff <= changed_in;
         started_ff <= started_in;
         total_ff   <= total_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      v_ff    <= v_in;
      newv_ff <= newv_in;
      chk_ff  <= chk_in;
      lhs_ff  <= lhs_in;
      dt_ff   <= dt_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      if (out_load) begin
         out_ff <= out_data;
      end
   end

   // result channel
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.out_channel    = out_ff.out_channel;
   assign rsp_chan.stored_value   = out_ff.stored_value;
   assign rsp_chan.validity       = out_ff.validity;
   assign rsp_chan.prior_validity = out_ff.prior_validity;
   assign rsp_chan.accepted       = out_ff.accepted;
   assign rsp_chan.degraded       = out_ff.degraded;
   assign rsp_chan.bad_count      = out_ff.bad_count;
   assign rsp_chan.hits           = out_ff.hits;
   assign rsp_chan.last           = out_ff.last;

endmodule

`default_nettype wire

>>> hw/rtl/signal_plausibility_table_core.sv
// Top level of the signal plausibility table: front end, queue and back end.
// Depends on spt_pkg, spt_req_if, spt_rsp_if, spt_front, spt_back.
//
//   channel    port       direction  items
//   request    req_chan   in         define / update / scan commands
//   result     rsp_chan   out        one per define/update/drop; changes + close per scan
//
// A define pops the queue and reads the RAM, then decides; an update does the
// same pop and read, then forms the rate product in two 31x24 halves and does
// the write-back. A scan walks the N channels through the single read port of
// the channel RAM, first marking stale channels and then listing them.
// Reset clears the defined map, counters and handshake state at once; the
// channel RAM needs no clearing pass.
// The two-entry queue keeps taking items while the result register waits, until both entries are full.
`default_nettype none

module signal_plausibility_table_core import spt_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   spt_req_if.sink   req_chan,
   spt_rsp_if.source rsp_chan
);

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   spt_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop)
   );

   spt_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
